FILE: rtl/sikm_pkg.sv
package sikm_pkg;

   // width of the length register
   localparam int CFG_W = 11;
   // sample width and difference width
   localparam int SAMPLE_W = 32;
   localparam int DIFF_W = SAMPLE_W + 1;
   // stream payload widths, padded to whole bytes
   localparam int REQ_W = 40;
   localparam int RSP_W = 40;
   localparam int COUNT_W = 32;

   // operation codes on the request stream
   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_PATTERN = 2'd1,
      OP_TEXT    = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   // commands passed from the front to the matching engine
   typedef enum logic [2:0] {
      CMD_CLEAR     = 3'd0,
      CMD_ADD       = 3'd1,
      CMD_TXT_RESET = 3'd2,
      CMD_TXT_FIRST = 3'd3,
      CMD_TXT_ALL   = 3'd4,
      CMD_TXT_KMP   = 3'd5
   } cmd_type;

   typedef struct packed {
      cmd_type                   kind;
      logic signed [DIFF_W-1:0]  diff;
   } cmd_entry_type;

endpackage

FILE: rtl/sikm_queue.sv
module sikm_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  sikm_pkg::cmd_entry_type push_data,
   output logic                    full,
   input  logic                    pop,
   output logic                    valid,
   output sikm_pkg::cmd_entry_type pop_data
);
   import sikm_pkg::*;

   cmd_entry_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    fill_ff, fill_in;

   assign full     = (fill_ff == 2'd2);
   assign valid    = (fill_ff != 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/sikm_front.sv
module sikm_front #(
   parameter int LENW = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sikm_pkg::REQ_W-1:0]    req_tdata,
   input  logic [LENW-1:0]               len,
   output logic                          push,
   output sikm_pkg::cmd_entry_type       push_data,
   input  logic                          q_full
);
   import sikm_pkg::*;

   op_type                     op;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       take;

   logic signed [SAMPLE_W-1:0] prev_pat_ff, prev_pat_in;
   logic signed [SAMPLE_W-1:0] prev_txt_ff, prev_txt_in;
   logic [LENW-1:0]            loaded_ff, loaded_in;
   logic                       started_ff, started_in;

   assign op         = op_type'(req_tdata[1:0]);
   assign sample     = req_tdata[SAMPLE_W+1:2];
   assign req_tready = ~q_full;
   assign take       = req_tvalid & req_tready;

   // classify each request and form the sample difference
   always_comb begin
      prev_pat_in    = prev_pat_ff;
      prev_txt_in    = prev_txt_ff;
      loaded_in      = loaded_ff;
      started_in     = started_ff;
      push           = 1'b0;
      push_data.kind = CMD_CLEAR;
      push_data.diff = '0;
      if (take) begin
         unique case (op)
            OP_CLEAR: begin
               prev_pat_in = '0;
               prev_txt_in = '0;
               loaded_in   = '0;
               started_in  = 1'b0;
               push        = 1'b1;
            end
            OP_PATTERN: begin
               if (loaded_ff < len) begin
                  if (loaded_ff != '0) begin
                     push           = 1'b1;
                     push_data.kind = CMD_ADD;
                     push_data.diff = DIFF_W'(sample) - DIFF_W'(prev_pat_ff);
                  end
                  prev_pat_in = sample;
                  loaded_in   = loaded_ff + LENW'(1);
               end
            end
            OP_TEXT: begin
               push = 1'b1;
               priority if (loaded_ff < len) begin
                  push_data.kind = CMD_TXT_RESET;
               end else if (len == LENW'(1)) begin
                  push_data.kind = CMD_TXT_ALL;
               end else if (!started_ff) begin
                  push_data.kind = CMD_TXT_FIRST;
               end else begin
                  push_data.kind = CMD_TXT_KMP;
                  push_data.diff = DIFF_W'(sample) - DIFF_W'(prev_txt_ff);
               end
               prev_txt_in = sample;
               started_in  = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pat_ff <= '0;
         prev_txt_ff <= '0;
         loaded_ff   <= '0;
         started_ff  <= 1'b0;
      end else begin
         prev_pat_ff <= prev_pat_in;
         prev_txt_ff <= prev_txt_in;
         loaded_ff   <= loaded_in;
         started_ff  <= started_in;
      end
   end

endmodule

FILE: rtl/sikm_back.sv
module sikm_back #(
   parameter int MAX_PATTERN = 1024,
   parameter int LW = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  sikm_pkg::cmd_entry_type       q_data,
   output logic                          q_pop,
   input  logic [LW-1:0]                 d,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_match,
   output logic [sikm_pkg::COUNT_W-1:0]  rsp_count
);
   import sikm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_LOAD  = 3'b010,
      ST_CHECK = 3'b100
   } state_type;

   // pattern differences and failure links
   logic signed [DIFF_W-1:0] p_mem [MAX_PATTERN-1];
   logic [LW-1:0]            f_mem [MAX_PATTERN];

   state_type                state_ff, state_in;
   logic [LW-1:0]            cur_ff, cur_in;
   logic signed [DIFF_W-1:0] x_ff, x_in;
   logic                     is_add_ff, is_add_in;
   logic [LW-1:0]            widx_ff, widx_in;
   logic [LW-1:0]            matched_ff, matched_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_match_ff, rsp_match_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;

   logic signed [DIFF_W-1:0] p_rd_ff;
   logic [LW-1:0]            f_rd_ff;
   logic [LW-1:0]            rd_addr;
   logic                     p_we, f_we;
   logic [LW-1:0]            f_waddr, f_wdata;
   logic signed [DIFF_W-1:0] p_wdata;

   logic                     out_free;
   logic                     emit, hit;
   logic                     same, go_on;
   logic [LW-1:0]            m_next;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_match = rsp_match_ff;
   assign rsp_count = rsp_count_ff;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign same      = (p_rd_ff == x_ff);
   assign m_next    = same ? cur_ff + LW'(1) : cur_ff;

   // engine control
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      x_in         = x_ff;
      is_add_in    = is_add_ff;
      widx_in      = widx_ff;
      matched_in   = matched_ff;
      count_in     = count_ff;
      rd_addr      = cur_ff;
      q_pop        = 1'b0;
      p_we         = 1'b0;
      p_wdata      = q_data.diff;
      f_we         = 1'b0;
      f_waddr      = widx_ff + LW'(1);
      f_wdata      = '0;
      emit         = 1'b0;
      hit          = 1'b0;
      go_on        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               unique case (q_data.kind)
                  CMD_CLEAR: begin
                     q_pop      = 1'b1;
                     matched_in = '0;
                     count_in   = '0;
                     widx_in    = '0;
                  end
                  CMD_ADD: begin
                     q_pop = 1'b1;
                     p_we  = 1'b1;
                     if (widx_ff == '0) begin
                        // first difference: link of the one-long prefix is zero
                        f_we    = 1'b1;
                        widx_in = widx_ff + LW'(1);
                     end else begin
                        rd_addr   = widx_ff;
                        x_in      = q_data.diff;
                        is_add_in = 1'b1;
                        state_in  = ST_LOAD;
                     end
                  end
                  CMD_TXT_RESET: begin
                     if (out_free) begin
                        q_pop      = 1'b1;
                        matched_in = '0;
                        emit       = 1'b1;
                     end
                  end
                  CMD_TXT_FIRST: begin
                     if (out_free) begin
                        q_pop = 1'b1;
                        emit  = 1'b1;
                     end
                  end
                  CMD_TXT_ALL: begin
                     if (out_free) begin
                        q_pop = 1'b1;
                        emit  = 1'b1;
                        hit   = 1'b1;
                     end
                  end
                  CMD_TXT_KMP: begin
                     q_pop     = 1'b1;
                     x_in      = q_data.diff;
                     is_add_in = 1'b0;
                     cur_in    = matched_ff;
                     rd_addr   = matched_ff;
                     state_in  = ST_CHECK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD: begin
            // start the fallback from the link of the previous prefix
            cur_in   = f_rd_ff;
            rd_addr  = f_rd_ff;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (is_add_ff) begin
               go_on = (cur_ff != '0) && !same;
            end else begin
               go_on = (cur_ff != '0) && ((cur_ff >= d) || !same);
            end
            if (go_on) begin
               cur_in  = f_rd_ff;
               rd_addr = f_rd_ff;
            end else if (is_add_ff) begin
               f_we     = 1'b1;
               f_wdata  = same ? cur_ff + LW'(1) : '0;
               widx_in  = widx_ff + LW'(1);
               state_in = ST_IDLE;
            end else if (out_free) begin
               matched_in = m_next;
               emit       = 1'b1;
               hit        = (m_next == d);
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // result register and saturating count
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_match_in = rsp_match_ff;
      rsp_count_in = rsp_count_ff;
      if (emit) begin
         if (hit && (count_ff != '1)) begin
            count_in = count_ff + COUNT_W'(1);
         end
         rsp_valid_in = 1'b1;
         rsp_match_in = hit;
         rsp_count_in = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         is_add_ff    <= 1'b0;
         widx_ff      <= '0;
         matched_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         is_add_ff    <= is_add_in;
         widx_ff      <= widx_in;
         matched_ff   <= matched_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      x_ff         <= x_in;
      rsp_match_ff <= rsp_match_in;
      rsp_count_ff <= rsp_count_in;
   end

   // difference table, registered read
   always_ff @(posedge clock) begin
      if (p_we) begin
         p_mem[widx_ff] <= p_wdata;
      end
      if (rd_addr < LW'(MAX_PATTERN - 1)) begin
         p_rd_ff <= p_mem[rd_addr];
      end
   end

   // failure link table, registered read
   always_ff @(posedge clock) begin
      if (f_we) begin
         f_mem[f_waddr] <= f_wdata;
      end
      f_rd_ff <= f_mem[rd_addr];
   end

endmodule

FILE: rtl/shift_invariant_kmp_matcher.sv
// channel  | direction | payload (low bit first)
// req      | in        | tdata: operation[1:0], sample_value[33:2], zero pad
// rsp      | out       | tdata: match[0], match_count[32:1], zero pad
// csr      | in        | wr_data: pattern_length, written when wr_en is high
//
// The front takes one request per cycle into a two-entry command queue while the queue is not full.
// Clear, short text and first-sample commands are done in the idle state; a text
// sample that is matched goes on to the check state and its failure-link steps,
// a pattern sample to the load state first (the first difference is written from idle).
// Each step is bound by the registered read of the two table memories.
// Reset clears control state; tables need no clearing. The engine holds a
// text result until the result register is free.
module shift_invariant_kmp_matcher #(
   parameter int MAX_PATTERN = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [sikm_pkg::REQ_W-1:0]  req_tdata,   // operation, sample_value
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [sikm_pkg::RSP_W-1:0]  rsp_tdata,   // match, match_count
   input  logic                        csr_wr_en,
   input  logic [sikm_pkg::CFG_W-1:0]  csr_wr_data
);
   import sikm_pkg::*;

   localparam int LW   = $clog2(MAX_PATTERN);
   localparam int LENW = $clog2(MAX_PATTERN + 1);
   localparam int EW   = (LENW > CFG_W) ? LENW : CFG_W;

   logic [CFG_W-1:0]   len_reg_ff;
   logic [EW-1:0]      len_wide;
   logic [EW-1:0]      len_clamp;
   logic [LENW-1:0]    len_eff;
   logic [LW-1:0]      d;

   logic               push, q_full, q_valid, q_pop;
   cmd_entry_type      push_data, q_data;
   logic               rsp_match;
   logic [COUNT_W-1:0] rsp_count;

   // length register
   always_ff @(posedge clock) begin
      if (reset) begin
         len_reg_ff <= CFG_W'(1);
      end else if (csr_wr_en) begin
         len_reg_ff <= csr_wr_data;
      end
   end

   // clamp length to 1..MAX_PATTERN
   always_comb begin
      len_wide = EW'(len_reg_ff);
      priority if (len_wide == '0) begin
         len_clamp = EW'(1);
      end else if (len_wide > EW'(MAX_PATTERN)) begin
         len_clamp = EW'(MAX_PATTERN);
      end else begin
         len_clamp = len_wide;
      end
      len_eff = len_clamp[LENW-1:0];
      d       = LW'(len_clamp - EW'(1));
   end

   sikm_front #(
      .LENW (LENW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .len        (len_eff),
      .push       (push),
      .push_data  (push_data),
      .q_full     (q_full)
   );

   sikm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_data)
   );

   sikm_back #(
      .MAX_PATTERN (MAX_PATTERN),
      .LW          (LW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .d         (d),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_match (rsp_match),
      .rsp_count (rsp_count)
   );

   assign rsp_tdata = {(RSP_W - COUNT_W - 1)'(0), rsp_count, rsp_match};

endmodule
